/* sv/mf3_pkg.sv */
package mf3_pkg;

  localparam int PIX_W = 8;                  // gray pixel width
  localparam int TAPS = 9;                   // 3x3 window
  localparam int CFG_W = 13;                 // widest configuration register
  localparam int IMG_W_BITS = 11;            // image_width register width
  localparam int HW = 13;                    // height value width (up to 4096)
  localparam int MAX_HEIGHT = 4096;
  localparam int FIFO_DEPTH = 8;             // result queue entries
  localparam int FIFO_AW = 3;
  localparam int FIFO_CW = 4;                // occupancy counter width

  localparam logic CFG_WIDTH  = 1'b0;        // register index of image_width
  localparam logic CFG_HEIGHT = 1'b1;        // register index of image_height

  typedef logic [PIX_W-1:0] pix_t;

endpackage

/* sv/median_filter_3x3.sv */
// 3x3 median filter on a raster stream of 8-bit gray pixels, mirror padded.
// input channel (s_*): one pixel per transaction; s_tuser = 1 marks a flush
// transaction that carries no pixel and drains one pending result of the
// last rows of a frame. output channel (m_*): one median per result, m_tlast
// marks the last pixel of the frame.
// the result for a pixel is produced when the transaction width+1 items
// later is accepted (pixel or flush); from that acceptance it passes the
// ram read, window/row sort, final sort and queue before m_tvalid shows it.
// throughput: one transaction per clock while ready, set by the single ram
// read per item on each line store and the two-stage selection network.
// the filtered results pass an 8-entry queue; s_tready drops only when the
// results in flight plus those queued would overfill it, so a stalled
// receiver backs the input up after a few transactions and nothing is lost.
// reset (rst, synchronous) clears counters, window and queue and loads
// width 640 and height 480; line stores keep their contents. a write on the
// configuration port restarts the frame; write only while idle.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  // input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] gray_in
  input  logic                     s_tuser,   // [0] flush
  // output stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,   // [7:0] median_out
  output logic                     m_tlast,   // frame_last
  // configuration writes
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);       // column index bits
  localparam int WW = $clog2(MAX_WIDTH + 1);   // width value bits
  localparam int FW = $clog2(MAX_WIDTH + 2);   // fill count bits
  localparam int RW = mf3_pkg::HW - 1;         // row index bits

  // clamp helpers for the register values
  function automatic logic [WW-1:0] clamp_width(input logic [mf3_pkg::IMG_W_BITS-1:0] v);
    logic [WW-1:0] r;
    if (32'(v) < 2) begin
      r = WW'(2);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [mf3_pkg::HW-1:0] clamp_height(input logic [mf3_pkg::CFG_W-1:0] v);
    logic [mf3_pkg::HW-1:0] r;
    if (32'(v) < 2) begin
      r = mf3_pkg::HW'(2);
    end else if (32'(v) > mf3_pkg::MAX_HEIGHT) begin
      r = mf3_pkg::HW'(mf3_pkg::MAX_HEIGHT);
    end else begin
      r = mf3_pkg::HW'(v);
    end
    return r;
  endfunction

  // compare-exchange: {min, max}
  function automatic logic [2*mf3_pkg::PIX_W-1:0] sort2(input mf3_pkg::pix_t a,
                                                       input mf3_pkg::pix_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  // effective geometry and stream position
  logic [WW-1:0]          w_eff;
  logic [mf3_pkg::HW-1:0] h_eff;
  logic [CW-1:0]          in_column;
  logic [RW-1:0]          in_row;
  logic [CW-1:0]          ocol;       // position of the next result
  logic [RW-1:0]          orow;
  logic [FW-1:0]          fill;       // pixels in whose results are pending

  // handshake
  logic s_acc, pop;
  logic [mf3_pkg::FIFO_CW-1:0] fifo_count;
  logic [mf3_pkg::FIFO_CW-1:0] inflight;

  // ------------------------------------------------------------------
  // input decision: what this transaction does, computed at acceptance
  // ------------------------------------------------------------------
  logic            at_start, restart, do_shift, do_emit;
  logic [FW-1:0]   lag, fill_base, fill_inc, fill_next;
  logic [CW-1:0]   rd_col, pix_col, in_column_next, ocol_use, ocol_next;
  logic [RW-1:0]   in_row_next, orow_use, orow_next;
  logic            ocol_at_end;

  always_comb begin
    lag         = FW'(w_eff) + FW'(1);
    at_start    = (in_column == '0) && (in_row == '0);
    restart     = !s_tuser && at_start && (fill != '0) && (fill < lag);
    ocol_use    = restart ? '0 : ocol;
    orow_use    = restart ? '0 : orow;
    ocol_at_end = (WW'(ocol_use) == w_eff - WW'(1));
    pix_col     = (WW'(in_column) >= w_eff) ? '0 : in_column;
    fill_base   = restart ? '0 : fill;
    fill_inc    = fill_base + FW'(1);

    in_column_next = in_column;
    in_row_next    = in_row;
    do_shift       = 1'b0;
    do_emit        = 1'b0;
    fill_next      = fill;

    if (s_tuser) begin
      // flush reads the column just right of the next output column
      rd_col = ocol_at_end ? '0 : ocol_use + CW'(1);
      if (at_start && (fill != '0)) begin
        do_shift  = 1'b1;
        do_emit   = 1'b1;
        fill_next = fill - FW'(1);
      end
    end else begin
      rd_col   = pix_col;
      do_shift = 1'b1;
      if (WW'(pix_col) == w_eff - WW'(1)) begin
        in_column_next = '0;
        in_row_next    = (mf3_pkg::HW'(in_row) == h_eff - mf3_pkg::HW'(1)) ?
                         '0 : in_row + RW'(1);
      end else begin
        in_column_next = pix_col + CW'(1);
      end
      if (fill_inc > lag) begin
        fill_next = lag;
        do_emit   = 1'b1;
      end else begin
        fill_next = fill_inc;
      end
    end

    // output position advance
    if (ocol_at_end) begin
      ocol_next = '0;
      orow_next = (mf3_pkg::HW'(orow_use) == h_eff - mf3_pkg::HW'(1)) ?
                  '0 : orow_use + RW'(1);
    end else begin
      ocol_next = ocol_use + CW'(1);
      orow_next = orow_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff     <= clamp_width(mf3_pkg::IMG_W_BITS'(640));
      h_eff     <= mf3_pkg::HW'(480);
      in_column <= '0;
      in_row    <= '0;
      ocol      <= '0;
      orow      <= '0;
      fill      <= '0;
    end else if (cfg_wr_en) begin
      // any register write starts a new frame
      if (cfg_index == mf3_pkg::CFG_WIDTH) begin
        w_eff <= clamp_width(cfg_data[mf3_pkg::IMG_W_BITS-1:0]);
      end else begin
        h_eff <= clamp_height(cfg_data);
      end
      in_column <= '0;
      in_row    <= '0;
      ocol      <= '0;
      orow      <= '0;
      fill      <= '0;
    end else if (s_acc) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      fill      <= fill_next;
      if (do_emit) begin
        ocol <= ocol_next;
        orow <= orow_next;
      end else if (restart) begin
        ocol <= '0;
        orow <= '0;
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: line store read data arrives, window shifts, stores update
  // ------------------------------------------------------------------
  logic            p1_shift, p1_emit, p1_flush, p1_last;
  logic            p1_lf, p1_rt, p1_tp, p1_bt;
  mf3_pkg::pix_t   p1_x;
  logic [CW-1:0]   p1_col;
  mf3_pkg::pix_t   rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_shift <= 1'b0;
      p1_emit  <= 1'b0;
    end else begin
      p1_shift <= s_acc && do_shift;
      p1_emit  <= s_acc && do_emit;
    end
    p1_flush <= s_tuser;
    p1_x     <= s_tdata;
    p1_col   <= rd_col;
    p1_lf    <= (ocol_use == '0);
    p1_rt    <= ocol_at_end;
    p1_tp    <= (orow_use == '0);
    p1_bt    <= (mf3_pkg::HW'(orow_use) >= h_eff - mf3_pkg::HW'(1));
    p1_last  <= ocol_at_end &&
                (mf3_pkg::HW'(orow_use) >= h_eff - mf3_pkg::HW'(1));
  end

  // line store a holds the row above the incoming one, b the row above that
  mf3_ram #(.DATA_W(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (p1_shift && !p1_flush),
    .waddr (p1_col),
    .wdata (p1_x),
    .raddr (rd_col),
    .rdata (rd_a)
  );

  mf3_ram #(.DATA_W(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (p1_shift && !p1_flush),
    .waddr (p1_col),
    .wdata (rd_a),
    .raddr (rd_col),
    .rdata (rd_b)
  );

  // window: index = column * 3 + row, column 2 newest
  mf3_pkg::pix_t win [mf3_pkg::TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mf3_pkg::TAPS; i++) begin
        win[i] <= '0;
      end
    end else if (p1_shift) begin
      for (int i = 0; i < mf3_pkg::TAPS - 3; i++) begin
        win[i] <= win[i+3];
      end
      win[6] <= rd_b;
      win[7] <= rd_a;
      win[8] <= p1_flush ? '0 : p1_x;
    end
  end

  logic p2_emit, p2_last, p2_lf, p2_rt, p2_tp, p2_bt;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_emit <= 1'b0;
    end else begin
      p2_emit <= p1_emit;
    end
    p2_last <= p1_last;
    p2_lf   <= p1_lf;
    p2_rt   <= p1_rt;
    p2_tp   <= p1_tp;
    p2_bt   <= p1_bt;
  end

  // ------------------------------------------------------------------
  // stage 2: mirror padding and row sorts
  // ------------------------------------------------------------------
  mf3_pkg::pix_t g [3][3];
  mf3_pkg::pix_t va [mf3_pkg::TAPS];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        g[r][c] = win[c*3+r];
      end
    end
    if (p2_lf) begin
      for (int r = 0; r < 3; r++) g[r][0] = g[r][2];
    end
    if (p2_rt) begin
      for (int r = 0; r < 3; r++) g[r][2] = g[r][0];
    end
    if (p2_tp) begin
      for (int c = 0; c < 3; c++) g[0][c] = g[2][c];
    end
    if (p2_bt) begin
      for (int c = 0; c < 3; c++) g[2][c] = g[0][c];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        va[r*3+c] = g[r][c];
      end
    end
    {va[1], va[2]} = sort2(va[1], va[2]);
    {va[4], va[5]} = sort2(va[4], va[5]);
    {va[7], va[8]} = sort2(va[7], va[8]);
    {va[0], va[1]} = sort2(va[0], va[1]);
    {va[3], va[4]} = sort2(va[3], va[4]);
    {va[6], va[7]} = sort2(va[6], va[7]);
    {va[1], va[2]} = sort2(va[1], va[2]);
    {va[4], va[5]} = sort2(va[4], va[5]);
    {va[7], va[8]} = sort2(va[7], va[8]);
  end

  logic          p3_valid, p3_last;
  mf3_pkg::pix_t p3_v [mf3_pkg::TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_emit;
    end
    p3_last <= p2_last;
    for (int i = 0; i < mf3_pkg::TAPS; i++) begin
      p3_v[i] <= va[i];
    end
  end

  // ------------------------------------------------------------------
  // stage 3: column merges down to the median
  // ------------------------------------------------------------------
  mf3_pkg::pix_t vb [mf3_pkg::TAPS];
  mf3_pkg::pix_t median;

  always_comb begin
    for (int i = 0; i < mf3_pkg::TAPS; i++) begin
      vb[i] = p3_v[i];
    end
    {vb[0], vb[3]} = sort2(vb[0], vb[3]);
    {vb[5], vb[8]} = sort2(vb[5], vb[8]);
    {vb[4], vb[7]} = sort2(vb[4], vb[7]);
    {vb[3], vb[6]} = sort2(vb[3], vb[6]);
    {vb[1], vb[4]} = sort2(vb[1], vb[4]);
    {vb[2], vb[5]} = sort2(vb[2], vb[5]);
    {vb[4], vb[7]} = sort2(vb[4], vb[7]);
    {vb[4], vb[2]} = sort2(vb[4], vb[2]);
    {vb[6], vb[4]} = sort2(vb[6], vb[4]);
    {vb[4], vb[2]} = sort2(vb[4], vb[2]);
    median = vb[4];
  end

  // ------------------------------------------------------------------
  // result queue and flow control
  // ------------------------------------------------------------------
  logic [mf3_pkg::PIX_W:0]     fifo_mem [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;

  assign pop      = m_tvalid && m_tready;
  assign s_acc    = s_tvalid && s_tready;
  // every result in the pipe has a queue slot reserved for it
  assign inflight = fifo_count + mf3_pkg::FIFO_CW'(p1_emit) +
                    mf3_pkg::FIFO_CW'(p2_emit) + mf3_pkg::FIFO_CW'(p3_valid);
  assign s_tready = (inflight < mf3_pkg::FIFO_CW'(mf3_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (p3_valid) begin
        wr_ptr <= wr_ptr + mf3_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mf3_pkg::FIFO_AW'(1);
      end
      if (p3_valid && !pop) begin
        fifo_count <= fifo_count + mf3_pkg::FIFO_CW'(1);
      end else if (!p3_valid && pop) begin
        fifo_count <= fifo_count - mf3_pkg::FIFO_CW'(1);
      end
    end
    if (p3_valid) begin
      fifo_mem[wr_ptr] <= {p3_last, median};
    end
  end

  assign m_tvalid = (fifo_count != '0);
  assign m_tdata  = fifo_mem[rd_ptr][mf3_pkg::PIX_W-1:0];
  assign m_tlast  = fifo_mem[rd_ptr][mf3_pkg::PIX_W];

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    inflight <= mf3_pkg::FIFO_CW'(mf3_pkg::FIFO_DEPTH))
    else $error("result queue reservation exceeded");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(w_eff) + FW'(1))
    else $error("pending count above window lag");

  a_idle_flush: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tuser && !at_start && !cfg_wr_en) |=> !p1_shift && !p1_emit)
    else $error("mid-frame flush touched the window");

  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    p3_valid |=> (fifo_count != '0))
    else $error("finished result not queued");

  a_emit_shifts: assert property (@(posedge clk) disable iff (rst)
    p1_emit |-> p1_shift)
    else $error("result without window update");

endmodule

/* sv/mf3_ram.sv */
module mf3_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
